@@ design/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg: sorted priority queue shared types
// Request/response payloads, request, status and ordering-mode codes, cell token control.
// ----------------------------------------------------------------------------
package spq_pkg;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] item_value;
        logic signed [31:0] item_priority;
    } t_req;

    typedef struct packed {
        logic signed [31:0] head_value;
        logic signed [31:0] head_priority;
        logic [1:0]         status;
        logic               is_empty;
        logic [4:0]         entry_count;
    } t_rsp;

    // request codes
    localparam logic [1:0] REQ_PUSH = 2'd0;
    localparam logic [1:0] REQ_POP  = 2'd1;
    localparam logic [1:0] REQ_PEEK = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // ordering modes
    localparam logic [1:0] MODE_ASC_FIFO  = 2'd0;
    localparam logic [1:0] MODE_ASC_LIFO  = 2'd1;
    localparam logic [1:0] MODE_DESC_FIFO = 2'd2;
    localparam logic [1:0] MODE_DESC_LIFO = 2'd3;

    // control of the insert token travelling down the cell row
    typedef struct packed {
        logic valid;   // token present
        logic shift;   // insertion point passed, displaced entries ride along
    } t_tok_ctl;

endpackage

@@ design/spq_cell.sv @@
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted queue
// Holds one entry; takes the insert token from its left neighbor and hands
// either the token or its displaced entry to the right; shifts left on pop.
// ----------------------------------------------------------------------------
module spq_cell #(
    parameter int VALUE_BITS    = 32,
    parameter int PRIORITY_BITS = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [1:0]               i_mode,
    input  spq_pkg::t_tok_ctl        i_tok,
    input  logic [VALUE_BITS-1:0]    i_tok_value,
    input  logic [PRIORITY_BITS-1:0] i_tok_prio,
    input  logic                     i_pop,
    input  logic                     i_nxt_valid,
    input  logic [VALUE_BITS-1:0]    i_nxt_value,
    input  logic [PRIORITY_BITS-1:0] i_nxt_prio,
    output logic                     o_valid,
    output logic [VALUE_BITS-1:0]    o_value,
    output logic [PRIORITY_BITS-1:0] o_prio,
    output spq_pkg::t_tok_ctl        o_tok,
    output logic [VALUE_BITS-1:0]    o_tok_value,
    output logic [PRIORITY_BITS-1:0] o_tok_prio
);
    import spq_pkg::*;

    logic                     r_valid, n_valid;
    logic [VALUE_BITS-1:0]    r_value, n_value;
    logic [PRIORITY_BITS-1:0] r_prio, n_prio;
    t_tok_ctl                 r_tok, n_tok;
    logic [VALUE_BITS-1:0]    r_tok_value, n_tok_value;
    logic [PRIORITY_BITS-1:0] r_tok_prio, n_tok_prio;
    logic                     w_holds;

    // relation of stored priority against the incoming one
    always_comb begin
        unique case (i_mode)
            MODE_ASC_FIFO:  w_holds = $signed(r_prio) <= $signed(i_tok_prio);
            MODE_ASC_LIFO:  w_holds = $signed(r_prio) <  $signed(i_tok_prio);
            MODE_DESC_FIFO: w_holds = $signed(r_prio) >= $signed(i_tok_prio);
            MODE_DESC_LIFO: w_holds = $signed(r_prio) >  $signed(i_tok_prio);
            default:        w_holds = 1'b0;
        endcase
    end

    always_comb begin
        n_valid     = r_valid;
        n_value     = r_value;
        n_prio      = r_prio;
        n_tok       = '0;
        n_tok_value = r_tok_value;
        n_tok_prio  = r_tok_prio;
        priority if (i_pop) begin
            n_valid = i_nxt_valid;
            n_value = i_nxt_value;
            n_prio  = i_nxt_prio;
        end else if (i_tok.valid) begin
            priority if (!r_valid) begin
                // first free slot: token lands here
                n_valid = 1'b1;
                n_value = i_tok_value;
                n_prio  = i_tok_prio;
            end else if (!i_tok.shift && w_holds) begin
                n_tok       = '{valid: 1'b1, shift: 1'b0};
                n_tok_value = i_tok_value;
                n_tok_prio  = i_tok_prio;
            end else begin
                // take the incoming entry, push ours one slot down
                n_value     = i_tok_value;
                n_prio      = i_tok_prio;
                n_tok       = '{valid: 1'b1, shift: 1'b1};
                n_tok_value = r_value;
                n_tok_prio  = r_prio;
            end
        end else begin
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tok   <= '0;
        end else begin
            r_valid <= n_valid;
            r_tok   <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value     <= n_value;
        r_prio      <= n_prio;
        r_tok_value <= n_tok_value;
        r_tok_prio  <= n_tok_prio;
    end

    assign o_valid     = r_valid;
    assign o_value     = r_value;
    assign o_prio      = r_prio;
    assign o_tok       = r_tok;
    assign o_tok_value = r_tok_value;
    assign o_tok_prio  = r_tok_prio;

endmodule

@@ design/sorted_priority_queue_core.sv @@
// ----------------------------------------------------------------------------
// sorted_priority_queue_core: bounded sorted priority queue
// A row of CAPACITY cells kept in priority order; slot 0 is the head.
// ----------------------------------------------------------------------------
// Usage:
//   Requests: drive i_req and raise start; the request transfers on a clock
//   edge where start is high and busy is low.
//   Responses: o_done pulses for one cycle, the cycle right after the request
//   transfer, with o_rsp valid. The receiver cannot stall; every response
//   must be taken in that cycle.
//   Pop, peek, dropped pushes and unknown request codes leave busy low, and
//   a new request may follow in the next cycle.
//   A push inserts a token into slot 0 that walks one cell per cycle until it
//   lands in the first free slot; busy stays high while a walk counter, loaded
//   with the entry count before the push, counts down to zero.
//   Configuration: i_cfg_data writes the ordering mode on i_cfg_valid;
//   o_cfg_ready is always high. Write it only while the queue is idle.
//   Reset (synchronous, i_rst_n low): queue empty, mode 0, busy low. Slot
//   contents are not cleared; only occupied slots are ever read.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core #(
    parameter int CAPACITY      = 16,
    parameter int VALUE_BITS    = 32,
    parameter int PRIORITY_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  spq_pkg::t_req i_req,
    output logic          o_done,
    output spq_pkg::t_rsp o_rsp,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [1:0]    i_cfg_data
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [1:0]       r_mode;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_walk, n_walk;
    logic             r_done;
    t_rsp             r_rsp, n_rsp;

    logic w_accept, w_full, w_empty, w_push, w_pop;

    t_tok_ctl                 w_tok       [CAPACITY];
    logic [VALUE_BITS-1:0]    w_tok_value [CAPACITY];
    logic [PRIORITY_BITS-1:0] w_tok_prio  [CAPACITY];
    logic                     w_valid     [CAPACITY];
    logic [VALUE_BITS-1:0]    w_value     [CAPACITY];
    logic [PRIORITY_BITS-1:0] w_prio      [CAPACITY];

    assign busy        = (r_walk != '0);
    assign w_accept    = start && !busy;
    assign w_full      = (r_count == CNT_W'(CAPACITY));
    assign w_empty     = (r_count == '0);
    assign w_push      = w_accept && (i_req.req_type == REQ_PUSH) && !w_full;
    assign w_pop       = w_accept && (i_req.req_type == REQ_POP) && !w_empty;
    assign o_cfg_ready = 1'b1;

    // token injection into the head cell
    assign w_tok[0]       = '{valid: w_push, shift: 1'b0};
    assign w_tok_value[0] = VALUE_BITS'(i_req.item_value);
    assign w_tok_prio[0]  = PRIORITY_BITS'(i_req.item_priority);

    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        if (gi < CAPACITY - 1) begin : g_mid
            spq_cell #(
                .VALUE_BITS    (VALUE_BITS),
                .PRIORITY_BITS (PRIORITY_BITS)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_mode      (r_mode),
                .i_tok       (w_tok[gi]),
                .i_tok_value (w_tok_value[gi]),
                .i_tok_prio  (w_tok_prio[gi]),
                .i_pop       (w_pop),
                .i_nxt_valid (w_valid[gi+1]),
                .i_nxt_value (w_value[gi+1]),
                .i_nxt_prio  (w_prio[gi+1]),
                .o_valid     (w_valid[gi]),
                .o_value     (w_value[gi]),
                .o_prio      (w_prio[gi]),
                .o_tok       (w_tok[gi+1]),
                .o_tok_value (w_tok_value[gi+1]),
                .o_tok_prio  (w_tok_prio[gi+1])
            );
        end else begin : g_last
            // the tail never emits a token: a push is never accepted when full
            spq_cell #(
                .VALUE_BITS    (VALUE_BITS),
                .PRIORITY_BITS (PRIORITY_BITS)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_mode      (r_mode),
                .i_tok       (w_tok[gi]),
                .i_tok_value (w_tok_value[gi]),
                .i_tok_prio  (w_tok_prio[gi]),
                .i_pop       (w_pop),
                .i_nxt_valid (1'b0),
                .i_nxt_value ('0),
                .i_nxt_prio  ('0),
                .o_valid     (w_valid[gi]),
                .o_value     (w_value[gi]),
                .o_prio      (w_prio[gi]),
                .o_tok       (),
                .o_tok_value (),
                .o_tok_prio  ()
            );
        end
    end

    always_comb begin
        n_count = r_count;
        n_rsp   = '0;
        n_rsp.status = ST_OK;
        unique case (i_req.req_type)
            REQ_PUSH: begin
                if (w_full) n_rsp.status = ST_FULL;
                else        n_count = r_count + 1'b1;
            end
            REQ_POP, REQ_PEEK: begin
                if (w_empty) begin
                    n_rsp.status = ST_EMPTY;
                end else begin
                    n_rsp.head_value    = 32'(w_value[0]);
                    n_rsp.head_priority = 32'(w_prio[0]);
                    if (i_req.req_type == REQ_POP) n_count = r_count - 1'b1;
                end
            end
            default: ;
        endcase
        n_rsp.is_empty    = (n_count == '0);
        n_rsp.entry_count = 5'(n_count);
    end

    // token lands in slot r_count; the walk counter starts at r_count and counts down
    always_comb begin
        priority if (w_push)  n_walk = r_count;
        else if (busy)        n_walk = r_walk - 1'b1;
        else                  n_walk = r_walk;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_ASC_FIFO;
            r_count <= '0;
            r_walk  <= '0;
            r_done  <= 1'b0;
        end else begin
            if (i_cfg_valid) r_mode <= i_cfg_data;
            if (w_accept)    r_count <= n_count;
            r_walk <= n_walk;
            r_done <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) r_rsp <= n_rsp;
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    // assertions
    a_done_follows_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(w_accept))
        else $error("response strobe without a request transfer");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (r_walk < r_count))
        else $error("insert walk longer than occupied slots");

    a_head_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid[0] == (r_count != '0))
        else $error("head slot valid flag disagrees with entry count");

endmodule

@@ bench/tb_sorted_priority_queue_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue_core: self-checking bench for the sorted queue
// A short directed table (empty, extreme, full and unknown-code cases) runs
// first; random phases follow, each mode twice, paired with idle patterns.
// Typed rows are checked against the table, the rest against a queue model.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue_core;

    import spq_pkg::*;

    localparam int         CAPACITY  = 16;
    localparam logic [1:0] REQ_NOP   = 2'd3;    // unknown code, answered with ST_OK and no state change
    localparam int         N_PHASES  = 8;
    localparam int         PHASE_LEN = 72;      // counted requests per random phase

    localparam logic [1:0] MODE_PLAN [N_PHASES] = '{
        MODE_ASC_FIFO, MODE_DESC_LIFO, MODE_ASC_LIFO, MODE_DESC_FIFO,
        MODE_DESC_FIFO, MODE_ASC_LIFO, MODE_DESC_LIFO, MODE_ASC_FIFO
    };
    localparam int IDLE_PLAN [4] = '{0, 78, 0, 13};

    typedef struct {
        t_req req;
        bit   typed;
        t_rsp rsp;
    } t_stim_row;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       start       = 1'b0;
    logic       busy;
    t_req       i_req       = '0;
    logic       o_done;
    t_rsp       o_rsp;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_data  = 2'd0;

    // queue model state
    logic signed [31:0] q_value [CAPACITY];
    logic signed [31:0] q_prio  [CAPACITY];
    int                 q_count    = 0;
    logic [1:0]         order_mode = MODE_ASC_FIFO;

    t_rsp      expected_responses [$];
    t_stim_row directed_rows [$];
    int        n_errors = 0;
    int        n_responses = 0;

    sorted_priority_queue_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_done      (o_done),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (n_errors < 100)
            $display("MISMATCH response %0d: %s", n_responses, msg);
        n_errors++;
    endtask

    // Applies one request to the model and returns the response it must produce.
    function automatic t_rsp predict_queue_request(input t_req r);
        t_rsp rsp;
        int   pos;
        bit   ahead;
        rsp = '0;
        case (r.req_type)
            REQ_PUSH: begin
                if (q_count >= CAPACITY) begin
                    rsp.status = ST_FULL;
                end else begin
                    // walk from the head while the stored entry stays in front
                    pos = 0;
                    while (pos < q_count) begin
                        case (order_mode)
                            MODE_ASC_FIFO:  ahead = $signed(q_prio[pos]) <= $signed(r.item_priority);
                            MODE_ASC_LIFO:  ahead = $signed(q_prio[pos]) <  $signed(r.item_priority);
                            MODE_DESC_FIFO: ahead = $signed(q_prio[pos]) >= $signed(r.item_priority);
                            default:        ahead = $signed(q_prio[pos]) >  $signed(r.item_priority);
                        endcase
                        if (!ahead)
                            break;
                        pos++;
                    end
                    for (int k = q_count; k > pos; k--) begin
                        q_value[k] = q_value[k-1];
                        q_prio[k]  = q_prio[k-1];
                    end
                    q_value[pos] = r.item_value;
                    q_prio[pos]  = r.item_priority;
                    q_count++;
                end
            end
            REQ_POP, REQ_PEEK: begin
                if (q_count == 0) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    rsp.head_value    = q_value[0];
                    rsp.head_priority = q_prio[0];
                    if (r.req_type == REQ_POP) begin
                        for (int k = 0; k < q_count - 1; k++) begin
                            q_value[k] = q_value[k+1];
                            q_prio[k]  = q_prio[k+1];
                        end
                        q_count--;
                    end
                end
            end
            default: ;
        endcase
        rsp.is_empty    = (q_count == 0);
        rsp.entry_count = q_count[4:0];
        return rsp;
    endfunction

    task automatic add_row(input logic [1:0] kind, input logic [31:0] value,
                           input logic [31:0] prio, input bit typed,
                           input logic [1:0] st, input logic emp, input logic [4:0] cnt);
        t_stim_row row;
        row.req.req_type      = kind;
        row.req.item_value    = value;
        row.req.item_priority = prio;
        row.typed             = typed;
        row.rsp               = '0;
        row.rsp.status        = st;
        row.rsp.is_empty      = emp;
        row.rsp.entry_count   = cnt;
        directed_rows.push_back(row);
    endtask

    // Holds the request until it transfers, then idles the sender at random.
    task automatic send_request(input t_req r, input bit typed, input t_rsp typed_rsp,
                                input int idle_pct);
        t_rsp predicted;
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        predicted = predict_queue_request(r);
        expected_responses.push_back(typed ? typed_rsp : predicted);
        if ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < idle_pct);
        end
    endtask

    // Waits for all responses and for the insert token to settle.
    task automatic drain_queue();
        start <= 1'b0;
        while (expected_responses.size() != 0 || busy)
            @(posedge i_clk);
        repeat (CAPACITY + 2) @(posedge i_clk);
    endtask

    task automatic write_order_mode(input logic [1:0] mode);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mode;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        order_mode = mode;
    endtask

    // response checker: o_done marks a one-cycle response, no back-pressure
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_done) begin
            if (expected_responses.size() == 0) begin
                report_mismatch("response with no request outstanding");
            end else begin
                want = expected_responses.pop_front();
                if (o_rsp.head_value !== want.head_value)
                    report_mismatch($sformatf("head_value got %0d expected %0d",
                                              o_rsp.head_value, want.head_value));
                if (o_rsp.head_priority !== want.head_priority)
                    report_mismatch($sformatf("head_priority got %0d expected %0d",
                                              o_rsp.head_priority, want.head_priority));
                if (o_rsp.status !== want.status)
                    report_mismatch($sformatf("status got %0d expected %0d",
                                              o_rsp.status, want.status));
                if (o_rsp.is_empty !== want.is_empty)
                    report_mismatch($sformatf("is_empty got %0b expected %0b",
                                              o_rsp.is_empty, want.is_empty));
                if (o_rsp.entry_count !== want.entry_count)
                    report_mismatch($sformatf("entry_count got %0d expected %0d",
                                              o_rsp.entry_count, want.entry_count));
            end
            n_responses++;
        end
    end

    initial begin
        t_req r;
        int   idle_pct;
        int   push_pct;
        int   counted;
        int   n_sent;
        int   pick;

        // directed rows, reset mode is ascending with FIFO ties
        add_row(REQ_POP,  32'h1234_5678, 32'h0000_0001, 1, ST_EMPTY, 1'b1, 5'd0);
        add_row(REQ_PEEK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, ST_EMPTY, 1'b1, 5'd0);
        add_row(REQ_NOP,  32'hA5A5_A5A5, 32'h5A5A_5A5A, 1, ST_OK,    1'b1, 5'd0);
        add_row(REQ_PUSH, 32'h7FFF_FFFF, 32'h8000_0000, 1, ST_OK,    1'b0, 5'd1);
        add_row(REQ_PUSH, 32'h8000_0000, 32'h7FFF_FFFF, 1, ST_OK,    1'b0, 5'd2);
        add_row(REQ_PUSH, 32'hFFFF_FFFF, 32'h0000_0000, 0, ST_OK,    1'b0, 5'd0);
        add_row(REQ_PUSH, 32'h0000_0005, 32'h0000_0000, 0, ST_OK,    1'b0, 5'd0);
        add_row(REQ_PEEK, 32'h0,         32'h0,         0, ST_OK,    1'b0, 5'd0);
        add_row(REQ_POP,  32'h0,         32'h0,         0, ST_OK,    1'b0, 5'd0);
        add_row(REQ_NOP,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, ST_OK,    1'b0, 5'd0);
        // fill to capacity with some repeated priorities
        for (int i = 0; i < 13; i++)
            add_row(REQ_PUSH, 32'h1000 + i, (i % 5) - 2, 0, ST_OK, 1'b0, 5'd0);
        add_row(REQ_PUSH, 32'hDEAD_BEEF, 32'h0000_0000, 1, ST_FULL, 1'b0, 5'd16);
        add_row(REQ_PEEK, 32'h0,         32'h0,         0, ST_OK,   1'b0, 5'd0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].typed,
                         directed_rows[i].rsp, 0);
        drain_queue();

        // random phases; entries carry over so each mode change meets a stored order
        n_sent   = 0;
        push_pct = 50;
        for (int ph = 0; ph < N_PHASES; ph++) begin
            write_order_mode(MODE_PLAN[ph]);
            idle_pct = IDLE_PLAN[ph % 4];
            counted  = 0;
            while (counted < PHASE_LEN) begin
                // bursts biased toward filling or emptying the queue
                if (n_sent % 16 == 0)
                    push_pct = 25 * $urandom_range(1, 3);
                pick = $urandom_range(0, 99);
                if (pick < 5)
                    r.req_type = REQ_NOP;
                else if (pick < 5 + push_pct)
                    r.req_type = REQ_PUSH;
                else
                    r.req_type = ($urandom_range(0, 2) == 0) ? REQ_PEEK : REQ_POP;
                r.item_value = $urandom;
                pick = $urandom_range(0, 9);
                if (pick < 5) begin
                    r.item_priority = $urandom_range(0, 6) - 3;
                end else if (pick < 7) begin
                    case ($urandom_range(0, 3))
                        0:       r.item_priority = 32'h8000_0000;
                        1:       r.item_priority = 32'h7FFF_FFFF;
                        2:       r.item_priority = 32'hFFFF_FFFF;
                        default: r.item_priority = 32'h0000_0000;
                    endcase
                end else begin
                    r.item_priority = $urandom;
                end
                send_request(r, 1'b0, '0, idle_pct);
                n_sent++;
                if (r.req_type != REQ_NOP)
                    counted++;
            end
            drain_queue();
        end

        if (n_errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
design/spq_pkg.sv
design/spq_cell.sv
design/sorted_priority_queue_core.sv
bench/tb_sorted_priority_queue_core.sv
